@@ rtl/core/hmt_pkg.sv @@
// Shared constants, codes and types of the hashed MAC address table.
package hmt_pkg;

    localparam int CMD_W       = 3;
    localparam int MAC_W       = 48;
    localparam int VLAN_W      = 12;
    localparam int PORT_IN_W   = 8;
    localparam int CNT_W       = 13;
    localparam int HASH_W      = 32;
    localparam int WAY_CNT_W   = 5;

    localparam int DEF_BUCKETS   = 1024;
    localparam int DEF_WAYS      = 4;
    localparam int DEF_PORT_BITS = 8;

    // Layout of one slot inside a bucket row.
    localparam int SLOT_VALID_BIT  = 0;
    localparam int SLOT_STATIC_BIT = 1;
    localparam int SLOT_MAC_LSB    = 2;
    localparam int SLOT_VLAN_LSB   = SLOT_MAC_LSB + MAC_W;
    localparam int SLOT_PORT_LSB   = SLOT_VLAN_LSB + VLAN_W;

    // Remainder unit: the reciprocal product, then the back-multiply.
    localparam int HASH_CYCLES = 2;
    localparam int HASH_CNT_W  = $clog2(HASH_CYCLES);

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    localparam logic [CMD_W-1:0] CMD_ADD_DYN    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_STATIC = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DEL_AGED   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FLUSH_VLAN = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FLUSH_PORT = 3'd4;
    localparam logic [CMD_W-1:0] CMD_FLUSH_ALL  = 3'd5;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_UPDATED  = 2'd1,
        ST_FULL     = 2'd2,
        ST_DONE     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_MODIFY,
        S_SWEEP,
        S_DONE
    } t_state;

    // Outcome of processing one bucket row.
    typedef struct packed {
        logic                 wr;
        t_status              status;
        logic [WAY_CNT_W-1:0] removed;
    } t_row_res;

endpackage

@@ rtl/core/hmt_mem.sv @@
// Single-port-write, registered-read memory holding one bucket row per entry.
module hmt_mem import hmt_pkg::*; #(
    parameter int DEPTH = DEF_BUCKETS,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/hmt_bucket.sv @@
// Per-row update logic: learn, aged delete and flush decisions over the slots of one bucket.
module hmt_bucket import hmt_pkg::*; #(
    parameter int WAYS      = DEF_WAYS,
    parameter int PORT_BITS = DEF_PORT_BITS
) (
    input  logic [CMD_W-1:0]                              i_cmd,
    input  logic [MAC_W-1:0]                              i_mac,
    input  logic [VLAN_W-1:0]                             i_vlan,
    input  logic [PORT_BITS-1:0]                          i_port,
    input  logic [WAYS*(SLOT_PORT_LSB+PORT_BITS)-1:0]     i_row,
    output logic [WAYS*(SLOT_PORT_LSB+PORT_BITS)-1:0]     o_row,
    output t_row_res                                      o_res
);

    localparam int SLOT_W = SLOT_PORT_LSB + PORT_BITS;

    logic [WAYS-1:0] v;
    logic [WAYS-1:0] st;
    logic [WAYS-1:0] hit;
    logic [WAYS-1:0] clr;
    logic            is_add;
    logic            add_static;
    logic            found;

    always_comb begin
        is_add     = (i_cmd == CMD_ADD_DYN) || (i_cmd == CMD_ADD_STATIC);
        add_static = (i_cmd == CMD_ADD_STATIC);
        for (int w = 0; w < WAYS; w++) begin
            v[w]   = i_row[w*SLOT_W + SLOT_VALID_BIT];
            st[w]  = i_row[w*SLOT_W + SLOT_STATIC_BIT];
            hit[w] = v[w] && (st[w] == add_static)
                     && (i_row[w*SLOT_W + SLOT_MAC_LSB +: MAC_W] == i_mac)
                     && (i_row[w*SLOT_W + SLOT_VLAN_LSB +: VLAN_W] == i_vlan);
            case (i_cmd)
                CMD_DEL_AGED: clr[w] = v[w] && !st[w]
                    && (i_row[w*SLOT_W + SLOT_MAC_LSB +: MAC_W] == i_mac)
                    && (i_row[w*SLOT_W + SLOT_VLAN_LSB +: VLAN_W] == i_vlan);
                CMD_FLUSH_VLAN: clr[w] = v[w] && !st[w]
                    && (i_row[w*SLOT_W + SLOT_VLAN_LSB +: VLAN_W] == i_vlan);
                CMD_FLUSH_PORT: clr[w] = v[w] && !st[w]
                    && (i_row[w*SLOT_W + SLOT_PORT_LSB +: PORT_BITS] == i_port);
                CMD_FLUSH_ALL: clr[w] = v[w] && !st[w];
                default: clr[w] = 1'b0;
            endcase
        end
    end

    always_comb begin
        o_row         = i_row;
        o_res.wr      = 1'b0;
        o_res.status  = ST_DONE;
        o_res.removed = '0;
        found         = 1'b0;
        if (is_add) begin
            // An existing entry of the same kind only gets its port refreshed.
            for (int w = 0; w < WAYS; w++) begin
                if (hit[w] && !found) begin
                    o_row[w*SLOT_W + SLOT_PORT_LSB +: PORT_BITS] = i_port;
                    found = 1'b1;
                end
            end
            if (found) begin
                o_res.wr     = 1'b1;
                o_res.status = ST_UPDATED;
            end else begin
                for (int w = 0; w < WAYS; w++) begin
                    if (!v[w] && !found) begin
                        o_row[w*SLOT_W +: SLOT_W] = {i_port, i_vlan, i_mac, add_static, 1'b1};
                        found = 1'b1;
                    end
                end
                o_res.wr     = found;
                o_res.status = found ? ST_INSERTED : ST_FULL;
            end
        end else begin
            for (int w = 0; w < WAYS; w++) begin
                if (clr[w]) begin
                    o_row[w*SLOT_W + SLOT_VALID_BIT] = 1'b0;
                end
                o_res.removed = o_res.removed + WAY_CNT_W'(clr[w]);
            end
            o_res.wr = |clr;
        end
    end

endmodule

@@ rtl/core/hashed_mac_address_table.sv @@
// Top level of the hashed MAC address table: sequencer, hash unit and result register.
// Adds and aged deletes step through accept, row read, modify/write back and result
// when BUCKETS is a power of two, with the reciprocal remainder unit ahead of the row
// read otherwise. Flushes sweep every row, reading each row while writing back the one before.
// One command is in flight at a time; a finished result may wait in the output register.
// After reset the table clears every row, one row per cycle, before taking commands.
module hashed_mac_address_table import hmt_pkg::*; #(
    parameter int BUCKETS   = DEF_BUCKETS,
    parameter int WAYS      = DEF_WAYS,
    parameter int PORT_BITS = DEF_PORT_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [CMD_W-1:0]     i_cmd,
    input  logic [MAC_W-1:0]     i_mac_addr,
    input  logic [VLAN_W-1:0]    i_vlan_id,
    input  logic [PORT_IN_W-1:0] i_port_id,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_status,
    output logic [CNT_W-1:0]     o_removed_count
);

    // Each memory entry is one bucket: WAYS slots of valid, static, MAC, VLAN and port.
    localparam int  SLOT_W  = SLOT_PORT_LSB + PORT_BITS;
    localparam int  ROW_W   = WAYS * SLOT_W;
    localparam int  RW      = $clog2(BUCKETS);
    localparam bit  IS_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;
    localparam logic [RW-1:0] LAST_ROW = RW'(BUCKETS - 1);
    // Reciprocal of BUCKETS scaled by 2^(HASH_W + RW), rounded up; exact for any 32-bit hash.
    localparam int  RECIP_SH = HASH_W + RW;
    localparam logic [HASH_W:0] RECIP =
        (HASH_W + 1)'(((64'd1 << RECIP_SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

    t_state                r_state, n_state;
    logic [CMD_W-1:0]      r_cmd;
    logic [MAC_W-1:0]      r_mac;
    logic [VLAN_W-1:0]     r_vlan;
    logic [PORT_BITS-1:0]  r_port;
    logic [RW-1:0]         r_row, n_row;
    logic [RW-1:0]         r_wr_row;
    logic                  r_pend, n_pend;
    logic                  r_rd_done, n_rd_done;
    logic [HASH_W-1:0]     r_hash, n_hash;
    logic [HASH_W-1:0]     r_quot, n_quot;
    logic [HASH_CNT_W-1:0] r_hcnt;
    logic [CNT_W-1:0]      r_count, n_count;
    t_status               r_res_status, n_res_status;
    logic                  r_o_valid;
    logic [1:0]            r_o_status;
    logic [CNT_W-1:0]      r_o_count;

    logic                  in_beat;
    logic                  out_load;
    logic                  is_flush;
    logic                  is_bucket_cmd;
    logic [HASH_W-1:0]     hash_in;
    logic [2*HASH_W:0]     recip_prod;
    logic [HASH_W-1:0]     quot_est;
    logic [HASH_W-1:0]     hash_rem;
    logic [CNT_W:0]        count_sum;
    logic                  mem_wr;
    logic [RW-1:0]         mem_wr_addr;
    logic [ROW_W-1:0]      mem_wr_data;
    logic [ROW_W-1:0]      mem_rd_data;
    logic [ROW_W-1:0]      new_row;
    t_row_res              row_res;

    assign o_ready   = (r_state == S_IDLE);
    assign in_beat   = i_valid && o_ready;
    assign out_load  = (r_state == S_DONE) && (!r_o_valid || i_ready);

    assign is_flush      = (i_cmd == CMD_FLUSH_VLAN) || (i_cmd == CMD_FLUSH_PORT)
                           || (i_cmd == CMD_FLUSH_ALL);
    assign is_bucket_cmd = (i_cmd == CMD_ADD_DYN) || (i_cmd == CMD_ADD_STATIC)
                           || (i_cmd == CMD_DEL_AGED);

    // Bucket hash: VLAN xor MAC octets 0..1 and 2..5, each group read little-endian.
    assign hash_in = {{(HASH_W - VLAN_W){1'b0}}, i_vlan_id}
                   ^ {16'b0, i_mac_addr[39:32], i_mac_addr[47:40]}
                   ^ {i_mac_addr[7:0], i_mac_addr[15:8], i_mac_addr[23:16], i_mac_addr[31:24]};

    // Remainder when BUCKETS is not a power of two: the quotient from the scaled
    // reciprocal is registered first, then the remainder is taken by back-multiplying it.
    assign recip_prod = {{(HASH_W + 1){1'b0}}, r_hash} * {{HASH_W{1'b0}}, RECIP};
    assign quot_est   = HASH_W'(recip_prod >> RECIP_SH);
    assign hash_rem   = r_hash - HASH_W'(r_quot * HASH_W'(BUCKETS));

    hmt_mem #(
        .DEPTH (BUCKETS),
        .WIDTH (ROW_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_addr (r_row),
        .o_rd_data (mem_rd_data)
    );

    hmt_bucket #(
        .WAYS      (WAYS),
        .PORT_BITS (PORT_BITS)
    ) u_bucket (
        .i_cmd  (r_cmd),
        .i_mac  (r_mac),
        .i_vlan (r_vlan),
        .i_port (r_port),
        .i_row  (mem_rd_data),
        .o_row  (new_row),
        .o_res  (row_res)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_row == LAST_ROW) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_beat) begin
                    if (is_flush) begin
                        n_state = S_SWEEP;
                    end else if (is_bucket_cmd) begin
                        n_state = IS_POW2 ? S_READ : S_HASH;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_HASH: begin
                if (r_hcnt == HASH_CNT_W'(HASH_CYCLES - 1)) n_state = S_READ;
            end
            S_READ:   n_state = S_MODIFY;
            S_MODIFY: n_state = S_DONE;
            S_SWEEP: begin
                // Finished once every row has been read and the last one written back.
                if (r_rd_done && r_pend) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        n_row        = r_row;
        n_pend       = 1'b0;
        n_rd_done    = r_rd_done;
        n_hash       = r_hash;
        n_quot       = r_quot;
        n_count      = r_count;
        n_res_status = r_res_status;
        mem_wr       = 1'b0;
        mem_wr_addr  = r_row;
        mem_wr_data  = new_row;
        count_sum    = {1'b0, r_count} + (CNT_W + 1)'(row_res.removed);
        case (r_state)
            S_CLEAR: begin
                mem_wr      = 1'b1;
                mem_wr_data = '0;
                n_row       = r_row + 1'b1;
            end
            S_IDLE: begin
                // A flush sweeps from row zero; a bucket command goes to its hashed row.
                n_row        = (IS_POW2 && !is_flush) ? hash_in[RW-1:0] : '0;
                n_hash       = hash_in;
                n_rd_done    = 1'b0;
                n_count      = '0;
                n_res_status = ST_DONE;
            end
            S_HASH: begin
                if (r_hcnt == '0) begin
                    n_quot = quot_est;
                end else begin
                    n_row = hash_rem[RW-1:0];
                end
            end
            S_MODIFY: begin
                mem_wr       = row_res.wr;
                n_res_status = row_res.status;
                n_count      = CNT_W'(row_res.removed);
            end
            S_SWEEP: begin
                // Read row r_row while row r_wr_row, read in the cycle before, is written back.
                if (!r_rd_done) begin
                    n_pend = 1'b1;
                    if (r_row == LAST_ROW) begin
                        n_rd_done = 1'b1;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end
                if (r_pend) begin
                    mem_wr      = row_res.wr;
                    mem_wr_addr = r_wr_row;
                    n_count     = (count_sum > (CNT_W + 1)'(COUNT_MAX))
                                  ? COUNT_MAX : count_sum[CNT_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_row     <= '0;
            r_pend    <= 1'b0;
            r_rd_done <= 1'b0;
            r_hcnt    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_row     <= n_row;
            r_pend    <= n_pend;
            r_rd_done <= n_rd_done;
            r_hcnt    <= (r_state == S_HASH) ? r_hcnt + 1'b1 : '0;
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Command fields and result payload.
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_cmd  <= i_cmd;
            r_mac  <= i_mac_addr;
            r_vlan <= i_vlan_id;
            r_port <= PORT_BITS'(i_port_id);
        end
        r_wr_row     <= r_row;
        r_hash       <= n_hash;
        r_quot       <= n_quot;
        r_count      <= n_count;
        r_res_status <= n_res_status;
        if (out_load) begin
            r_o_status <= r_res_status;
            r_o_count  <= r_count;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_status        = r_o_status;
    assign o_removed_count = r_o_count;

    // The memory is written only by the clearing pass, a bucket update or a sweep.
    a_wr_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_wr |-> (r_state == S_CLEAR || r_state == S_MODIFY || r_state == S_SWEEP))
        else $error("memory written outside clear, modify or sweep");

    // During a sweep the row being written back is never the row being read.
    a_sweep_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP && r_pend && !r_rd_done) |-> (r_wr_row != r_row))
        else $error("sweep write row collides with read row");

    // An add never removes entries and never reports a delete outcome.
    a_add_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MODIFY && (r_cmd == CMD_ADD_DYN || r_cmd == CMD_ADD_STATIC))
        |-> (row_res.removed == '0 && row_res.status != ST_DONE))
        else $error("add produced a delete result");

    // A result is loaded only after a command has been taken and worked on.
    a_load_after_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_DONE) |-> $past(r_state != S_CLEAR))
        else $error("result produced during the clearing pass");

endmodule

@@ test/hashed_mac_address_table_test.sv @@
// Testbench of the hashed MAC address table: directed table, then random commands against a model.
`timescale 1ns / 100ps

module hashed_mac_address_table_test import hmt_pkg::*; ();

    localparam int NBUCKETS = DEF_BUCKETS;
    localparam int NWAYS    = DEF_WAYS;
    localparam int NSLOTS   = NBUCKETS * NWAYS;
    localparam int WATCHDOG = 20000;
    localparam int NRANDOM  = 430;

    // Command codes with no function; the table must leave itself alone.
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [CMD_W-1:0]     i_cmd = '0;
    logic [MAC_W-1:0]     i_mac_addr = '0;
    logic [VLAN_W-1:0]    i_vlan_id = '0;
    logic [PORT_IN_W-1:0] i_port_id = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [1:0]           o_status;
    logic [CNT_W-1:0]     o_removed_count;

    hashed_mac_address_table i_dut (.*);

    always #6 i_clk = ~i_clk;

    // One expected result beat.
    typedef struct {
        t_status          status;
        logic [CNT_W-1:0] removed;
    } t_outcome;

    // One command beat, with an optional typed-in result.
    typedef struct {
        logic [CMD_W-1:0]     cmd;
        logic [MAC_W-1:0]     mac;
        logic [VLAN_W-1:0]    vlan;
        logic [PORT_IN_W-1:0] port;
        bit                   fixed;
        t_status              status;
        int                   removed;
    } t_command;

    // Shadow copy of the table that the predictor keeps.
    bit                   tbl_valid  [NSLOTS];
    bit                   tbl_static [NSLOTS];
    logic [MAC_W-1:0]     tbl_mac    [NSLOTS];
    logic [VLAN_W-1:0]    tbl_vlan   [NSLOTS];
    logic [PORT_IN_W-1:0] tbl_port   [NSLOTS];

    t_outcome  pending_results[$];
    int        error_count = 0;
    int        idle_cycles = 0;
    bit        quiet_phase = 1'b0;
    t_command  directed[$];
    logic [MAC_W-1:0] learned_macs[$];

    function automatic int bucket_index(logic [MAC_W-1:0] mac, logic [VLAN_W-1:0] vlan);
        logic [31:0] hi, lo;
        hi = {16'd0, mac[39:32], mac[47:40]};
        lo = {mac[7:0], mac[15:8], mac[23:16], mac[31:24]};
        return int'((32'(vlan) ^ hi ^ lo) % NBUCKETS);
    endfunction

    // Applies one command to the shadow table and returns the result it should give.
    function automatic t_outcome apply_command(t_command c);
        t_outcome r;
        int base, free_slot, cnt;
        bit kind, hit;
        r.status = ST_DONE;
        cnt = 0;
        base = bucket_index(c.mac, c.vlan) * NWAYS;
        if (c.cmd == CMD_ADD_DYN || c.cmd == CMD_ADD_STATIC) begin
            kind = (c.cmd == CMD_ADD_STATIC);
            free_slot = -1;
            r.status = ST_FULL;
            for (int w = 0; w < NWAYS; w++) begin
                if (tbl_valid[base+w]) begin
                    if (r.status == ST_FULL && tbl_static[base+w] == kind &&
                        tbl_mac[base+w] == c.mac && tbl_vlan[base+w] == c.vlan) begin
                        tbl_port[base+w] = c.port;
                        r.status = ST_UPDATED;
                    end
                end else if (free_slot < 0) begin
                    free_slot = base + w;
                end
            end
            if (r.status == ST_FULL && free_slot >= 0) begin
                tbl_valid[free_slot]  = 1'b1;
                tbl_static[free_slot] = kind;
                tbl_mac[free_slot]    = c.mac;
                tbl_vlan[free_slot]   = c.vlan;
                tbl_port[free_slot]   = c.port;
                r.status = ST_INSERTED;
            end
        end else if (c.cmd == CMD_DEL_AGED) begin
            for (int w = 0; w < NWAYS; w++) begin
                if (tbl_valid[base+w] && !tbl_static[base+w] &&
                    tbl_mac[base+w] == c.mac && tbl_vlan[base+w] == c.vlan) begin
                    tbl_valid[base+w] = 1'b0;
                    cnt++;
                end
            end
        end else if (c.cmd >= CMD_FLUSH_VLAN && c.cmd <= CMD_FLUSH_ALL) begin
            for (int s = 0; s < NSLOTS; s++) begin
                if (tbl_valid[s] && !tbl_static[s]) begin
                    if (c.cmd == CMD_FLUSH_VLAN)      hit = (tbl_vlan[s] == c.vlan);
                    else if (c.cmd == CMD_FLUSH_PORT) hit = (tbl_port[s] == c.port);
                    else                              hit = 1'b1;
                    if (hit) begin
                        tbl_valid[s] = 1'b0;
                        cnt++;
                    end
                end
            end
        end
        r.removed = (cnt > int'(COUNT_MAX)) ? COUNT_MAX : CNT_W'(cnt);
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        error_count++;
    endtask

    // Drives one command beat and waits for its acceptance. The beat is
    // predicted on acceptance, so the typed-in value rides along with it.
    // Valid drops only while the sender idles; back-to-back beats keep it high.
    task automatic send_command(t_command c);
        t_outcome want;
        while (!quiet_phase && $urandom_range(99) < 10) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_cmd      <= c.cmd;
        i_mac_addr <= c.mac;
        i_vlan_id  <= c.vlan;
        i_port_id  <= c.port;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        want = apply_command(c);
        if (c.fixed) begin
            if (want.status != c.status || int'(want.removed) != c.removed)
                report_mismatch("typed-in row disagrees with model", int'(want.status),
                                int'(c.status));
            want.status  = c.status;
            want.removed = CNT_W'(c.removed);
        end
        pending_results.push_back(want);
        @(negedge i_clk);
    endtask

    // Result side: random back-pressure on the falling edge, none in the quiet phase.
    always @(negedge i_clk) begin
        i_ready <= quiet_phase ? 1'b1 : ($urandom_range(99) >= 10);
    end

    // Check result beats and watch for a stalled run.
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WATCHDOG) begin
                $display("DONE: errors detected");
                $finish;
            end
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing expected", o_status, -1);
                end else begin
                    want = pending_results.pop_front();
                    if (o_status != want.status)
                        report_mismatch("status", o_status, int'(want.status));
                    if (o_removed_count != want.removed)
                        report_mismatch("removed_count", o_removed_count, int'(want.removed));
                end
            end
        end
    end

    function automatic t_command mk(logic [CMD_W-1:0] cmd, logic [MAC_W-1:0] mac,
                                    logic [VLAN_W-1:0] vlan, logic [PORT_IN_W-1:0] port,
                                    bit fixed = 1'b0, t_status st = ST_DONE, int rm = 0);
        t_command c;
        c.cmd = cmd; c.mac = mac; c.vlan = vlan; c.port = port;
        c.fixed = fixed; c.status = st; c.removed = rm;
        return c;
    endfunction

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (NBUCKETS + 20) @(posedge i_clk);
    endtask

    initial begin
        t_command c;
        int pick;
        for (int s = 0; s < NSLOTS; s++) begin
            tbl_valid[s] = 0; tbl_static[s] = 0; tbl_mac[s] = '0;
            tbl_vlan[s] = '0; tbl_port[s] = '0;
        end
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: the empty table, extremes, kind separation, a full
        // bucket, updates, deletes, each flush and the unused codes.
        directed.push_back(mk(CMD_DEL_AGED, '0, '0, '0, 1, ST_DONE, 0));
        directed.push_back(mk(CMD_FLUSH_ALL, '0, '0, '0, 1, ST_DONE, 0));
        directed.push_back(mk(CMD_ADD_DYN, '0, '0, '0, 1, ST_INSERTED, 0));
        directed.push_back(mk(CMD_ADD_DYN, '1, '1, '1, 1, ST_INSERTED, 0));
        directed.push_back(mk(CMD_ADD_DYN, '1, '1, 8'h5a, 1, ST_UPDATED, 0));
        directed.push_back(mk(CMD_ADD_STATIC, '1, '1, 8'h33, 1, ST_INSERTED, 0));
        directed.push_back(mk(CMD_ADD_STATIC, '1, '1, 8'h34, 1, ST_UPDATED, 0));
        directed.push_back(mk(CMD_ADD_DYN, 48'h0000_0000_0004, '0, 8'h01));
        directed.push_back(mk(CMD_ADD_DYN, 48'h0000_0000_0008, '0, 8'h01));
        directed.push_back(mk(CMD_ADD_DYN, 48'h0000_0000_0400, '0, 8'h02));
        directed.push_back(mk(CMD_ADD_DYN, 48'h0000_0000_0800, '0, 8'h02));
        directed.push_back(mk(CMD_ADD_DYN, 48'h0000_0000_0C00, '0, 8'h02));
        directed.push_back(mk(CMD_ADD_DYN, 48'h0000_0000_1000, '0, 8'h02));
        directed.push_back(mk(CMD_ADD_DYN, 48'h0000_0000_1400, '0, 8'h02));
        directed.push_back(mk(CMD_DEL_AGED, '1, '1, '0));
        directed.push_back(mk(CMD_DEL_AGED, '1, '1, '0, 1, ST_DONE, 0));
        directed.push_back(mk(CMD_FLUSH_PORT, '0, '0, 8'h02));
        directed.push_back(mk(CMD_FLUSH_VLAN, '0, 12'h000, '0));
        directed.push_back(mk(CMD_SPARE_LO, '1, '1, '1, 1, ST_DONE, 0));
        directed.push_back(mk(CMD_SPARE_HI, '0, '0, '0, 1, ST_DONE, 0));
        directed.push_back(mk(CMD_ADD_STATIC, 48'h0180_c200_0000, 12'hfff, 8'hff));
        directed.push_back(mk(CMD_FLUSH_ALL, '0, '0, '0));
        directed.push_back(mk(CMD_FLUSH_ALL, '0, '0, '0, 1, ST_DONE, 0));
        foreach (directed[i]) send_command(directed[i]);
        i_valid <= 1'b0;

        // Sender hold-off: let every expected result drain before going on.
        while (pending_results.size() != 0) @(negedge i_clk);

        // Random part: mostly adds and deletes over a small pool of MACs so
        // hits, full buckets and real removals happen; flushes are rarer
        // since each sweeps the whole table.
        for (int n = 0; n < NRANDOM; n++) begin
            quiet_phase = (n >= 150 && n < 220);
            pick = $urandom_range(99);
            c.mac  = MAC_W'({$urandom, $urandom});
            c.vlan = VLAN_W'($urandom_range(3));
            c.port = PORT_IN_W'($urandom_range(3));
            if ($urandom_range(9) == 0) begin
                c.vlan = VLAN_W'($urandom);
                c.port = PORT_IN_W'($urandom);
            end
            if (learned_macs.size() != 0 && $urandom_range(1))
                c.mac = learned_macs[$urandom_range(learned_macs.size() - 1)];
            else if ($urandom_range(3) == 0)
                c.mac = {c.mac[47:12], 12'h000} | 48'($urandom_range(7) * NBUCKETS);
            if (pick < 40)      c.cmd = CMD_ADD_DYN;
            else if (pick < 55) c.cmd = CMD_ADD_STATIC;
            else if (pick < 80) c.cmd = CMD_DEL_AGED;
            else if (pick < 86) c.cmd = CMD_FLUSH_VLAN;
            else if (pick < 92) c.cmd = CMD_FLUSH_PORT;
            else if (pick < 96) c.cmd = CMD_FLUSH_ALL;
            else                c.cmd = $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
            c.fixed = 1'b0;
            if (c.cmd <= CMD_ADD_STATIC && learned_macs.size() < 64)
                learned_macs.push_back(c.mac);
            send_command(c);
        end
        quiet_phase = 1'b0;
        i_valid <= 1'b0;

        wait_drained();
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
